/* rtl/gev_pkg.sv */
// Shared constants and lookup functions for the grid element vertex enumerator.
// Holds list kinds, status codes, register indexes and the corner tables.
// No dependencies.
`default_nettype none

package gev_pkg;

  localparam int VTX_W      = 24;
  localparam int PTS_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 200;
  localparam int VCNT_W     = 4;

  // func codes
  localparam logic [1:0] K_EDGE   = 2'd0;
  localparam logic [1:0] K_QUAD   = 2'd1;
  localparam logic [1:0] K_CUBE   = 2'd2;
  localparam logic [1:0] F_LOOKUP = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PZ = 2'd2;

  // axes that lose one point in a group: bit0 X, bit1 Y, bit2 Z
  function automatic logic [2:0] shrink_mask(input logic [1:0] kind, input logic [1:0] grp);
    logic [2:0] m;
    m = 3'b000;
    case (kind)
      K_EDGE: begin
        case (grp)
          2'd0:    m = 3'b001;
          2'd1:    m = 3'b010;
          2'd2:    m = 3'b100;
          default: m = 3'b000;
        endcase
      end
      K_QUAD: begin
        case (grp)
          2'd0:    m = 3'b011;
          2'd1:    m = 3'b101;
          2'd2:    m = 3'b110;
          default: m = 3'b000;
        endcase
      end
      K_CUBE:  m = 3'b111;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] grp_count(input logic [1:0] kind);
    logic [1:0] c;
    case (kind)
      K_EDGE:  c = 2'd3;
      K_QUAD:  c = 2'd3;
      K_CUBE:  c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [VCNT_W-1:0] vcount(input logic [1:0] kind);
    logic [VCNT_W-1:0] c;
    case (kind)
      K_EDGE:  c = 4'd2;
      K_QUAD:  c = 4'd4;
      K_CUBE:  c = 4'd8;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  // corner offset of vertex k: bit0 +x, bit1 +y, bit2 +z
  function automatic logic [2:0] corner(input logic [1:0] kind, input logic [1:0] grp,
                                        input logic [2:0] k);
    logic [2:0] c;
    c = 3'd0;
    case (kind)
      K_EDGE: c = (k == 3'd0) ? 3'd0 : (3'd1 << grp);
      K_QUAD: begin
        case (grp)
          2'd0: begin
            case (k[1:0])
              2'd0:    c = 3'd0;
              2'd1:    c = 3'd1;
              2'd2:    c = 3'd3;
              default: c = 3'd2;
            endcase
          end
          2'd1: begin
            case (k[1:0])
              2'd0:    c = 3'd0;
              2'd1:    c = 3'd1;
              2'd2:    c = 3'd5;
              default: c = 3'd4;
            endcase
          end
          default: begin
            case (k[1:0])
              2'd0:    c = 3'd0;
              2'd1:    c = 3'd2;
              2'd2:    c = 3'd6;
              default: c = 3'd4;
            endcase
          end
        endcase
      end
      K_CUBE:  c = k;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/gev_mac.sv */
// Shared multiply-add unit: r = a * b + c + cin, kept to the low 24 bits.
// Used for every vertex number step. Depends on gev_pkg.
`default_nettype none

module gev_mac #(
  parameter int AW = 9
) (
  input  logic [AW-1:0]             a,
  input  logic [gev_pkg::VTX_W-1:0] b,
  input  logic [gev_pkg::VTX_W-1:0] c,
  input  logic                      cin,
  output logic [gev_pkg::VTX_W-1:0] r
);
  import gev_pkg::*;

  logic [AW+VTX_W-1:0] prod;

  assign prod = {{VTX_W{1'b0}}, a} * {{AW{1'b0}}, b};
  assign r    = prod[VTX_W-1:0] + c + {{(VTX_W-1){1'b0}}, cin};

endmodule

`default_nettype wire

/* rtl/gev_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, 24-bit dividend.
// Produces quotient and remainder; done is high for a single cycle once the last step is registered.
`default_nettype none

module gev_div #(
  parameter int DW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gev_pkg::VTX_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [gev_pkg::VTX_W-1:0] quo,
  output logic [DW-1:0]             rem
);
  import gev_pkg::*;

  localparam int CW = $clog2(VTX_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quo[VTX_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(VTX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[VTX_W-2:0], ge};
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/grid_element_vertex_enumerator_core.sv */
// Top level of the grid element vertex enumerator: sequencer, list cursor,
// output register. Uses gev_pkg, gev_mac (shared multiply-add) and gev_div.
//
//  port group | dir | contents
//  s_*        | in  | request: tuser func, tdata restart + cube_number
//  m_*        | out | element: tdata vertices + count, tuser status, tlast
//  cfg_*      | in  | point counts along X, Y, Z (indexes 0, 1, 2)
//
// One request at a time. A list element is built by the base and plane-stride
// steps, then one pass of the shared multiply-add per vertex. A cube lookup
// first runs two serial divisions; an out-of-range number finishes after the
// second division, while an empty list or an empty grid skips the arithmetic.
// Reset is synchronous; no memories to clear. A new request is taken while a
// finished element waits in the output register; the sequencer holds in its
// last step only if that register is still full.
`default_nettype none

module grid_element_vertex_enumerator_core #(
  parameter int AXIS_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gev_pkg::IN_TDATA_W-1:0]   s_tdata,   // restart, cube_number, zero pad
  input  logic [1:0]                       s_tuser,   // func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gev_pkg::OUT_TDATA_W-1:0]  m_tdata,   // vertex_0..vertex_7, vertex_count, pad
  output logic [1:0]                       m_tuser,   // status
  output logic                             m_tlast,   // last_of_list
  input  logic                             cfg_we,
  input  logic [gev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gev_pkg::PTS_W-1:0]        cfg_data
);
  import gev_pkg::*;

  localparam int AB    = AXIS_BITS;
  localparam int NW    = AXIS_BITS + 1;
  localparam int LIMIT = 1 << AXIS_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // configuration
  logic [PTS_W-1:0] points_x, points_y, points_z;
  logic [NW-1:0]    n0, n1, n2;
  logic [NW-1:0]    nm0, nm1, nm2;
  logic             grid_ok;

  // sequencer and cursor
  logic [2:0]        state;
  logic [3:0]        step;
  logic [1:0]        cursor_kind, cursor_group;
  logic [AB-1:0]     cursor_x, cursor_y, cursor_z;
  logic [1:0]        wkind, wgrp;
  logic [AB-1:0]     wx, wy, wz;
  logic              is_list;
  logic [1:0]        res_status;
  logic [VCNT_W-1:0] res_count;
  logic              res_last;
  logic [VTX_W-1:0]  t_acc, base, base_z;
  logic [VTX_W-1:0]  vtx [8];

  // request fields
  logic [1:0]       in_func;
  logic             in_restart;
  logic [VTX_W-1:0] in_num;
  logic             accept;

  assign in_func    = s_tuser;
  assign in_restart = s_tdata[0];
  assign in_num     = s_tdata[VTX_W:1];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;

  function automatic logic [NW-1:0] eff(input logic [PTS_W-1:0] p);
    return (int'(p) > LIMIT) ? NW'(LIMIT) : NW'(p);
  endfunction

  function automatic logic [NW-1:0] ext(input logic [NW-1:0] n, input logic m);
    return (m && n != '0) ? n - NW'(1) : n;
  endfunction

  function automatic logic grp_ok(input logic [1:0] kind, input logic [1:0] g,
                                  input logic [NW-1:0] a0, input logic [NW-1:0] a1,
                                  input logic [NW-1:0] a2);
    logic [2:0] m;
    logic       ok;
    m  = shrink_mask(kind, g);
    ok = (kind <= K_CUBE) && (g < grp_count(kind));
    ok = ok && (ext(a0, m[0]) != '0) && (ext(a1, m[1]) != '0) && (ext(a2, m[2]) != '0);
    return ok;
  endfunction

  // returns {found, group}: lowest non-empty group at or after 'from'
  function automatic logic [2:0] first_grp(input logic [1:0] kind, input logic [2:0] from,
                                           input logic [NW-1:0] a0, input logic [NW-1:0] a1,
                                           input logic [NW-1:0] a2);
    logic [2:0] res;
    res = 3'd0;
    for (int g = 2; g >= 0; g--) begin
      if (g >= int'(from) && grp_ok(kind, 2'(g), a0, a1, a2)) res = {1'b1, 2'(g)};
    end
    return res;
  endfunction

  assign n0      = eff(points_x);
  assign n1      = eff(points_y);
  assign n2      = eff(points_z);
  assign nm0     = n0 - NW'(1);
  assign nm1     = n1 - NW'(1);
  assign nm2     = n2 - NW'(1);
  assign grid_ok = (n0 >= NW'(2)) && (n1 >= NW'(2)) && (n2 >= NW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      points_x <= PTS_W'(2);
      points_y <= PTS_W'(2);
      points_z <= PTS_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PX:  points_x <= cfg_data;
        REG_PY:  points_y <= cfg_data;
        REG_PZ:  points_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // list request: decide where the cursor stands before emitting
  logic [2:0]    dec_cur_m;
  logic          dec_valid;
  logic [2:0]    dec_first;
  logic          dec_empty;
  logic [1:0]    dec_grp;
  logic [AB-1:0] dec_x, dec_y, dec_z;

  always_comb begin
    dec_cur_m = shrink_mask(cursor_kind, cursor_group);
    dec_valid = (cursor_kind == in_func) && grp_ok(in_func, cursor_group, n0, n1, n2) &&
                ({1'b0, cursor_x} < ext(n0, dec_cur_m[0])) &&
                ({1'b0, cursor_y} < ext(n1, dec_cur_m[1])) &&
                ({1'b0, cursor_z} < ext(n2, dec_cur_m[2]));
    dec_first = first_grp(in_func, 3'd0, n0, n1, n2);
    dec_empty = 1'b0;
    dec_grp   = cursor_group;
    dec_x     = cursor_x;
    dec_y     = cursor_y;
    dec_z     = cursor_z;
    if (in_restart || !dec_valid) begin
      dec_x     = '0;
      dec_y     = '0;
      dec_z     = '0;
      dec_empty = !dec_first[2];
      dec_grp   = dec_first[2] ? dec_first[1:0] : 2'd0;
    end
  end

  // step the cursor past the element just emitted
  logic [2:0]    adv_m;
  logic [NW-1:0] ex, ey, ez;
  logic [NW-1:0] x1, y1, z1;
  logic [2:0]    adv_nxt, adv_wrap;
  logic [AB-1:0] adv_x, adv_y, adv_z;
  logic [1:0]    adv_grp;
  logic          adv_last;

  always_comb begin
    adv_m    = shrink_mask(cursor_kind, cursor_group);
    ex       = ext(n0, adv_m[0]);
    ey       = ext(n1, adv_m[1]);
    ez       = ext(n2, adv_m[2]);
    x1       = {1'b0, cursor_x} + NW'(1);
    y1       = {1'b0, cursor_y} + NW'(1);
    z1       = {1'b0, cursor_z} + NW'(1);
    adv_nxt  = first_grp(cursor_kind, {1'b0, cursor_group} + 3'd1, n0, n1, n2);
    adv_wrap = first_grp(cursor_kind, 3'd0, n0, n1, n2);
    adv_x    = x1[AB-1:0];
    adv_y    = cursor_y;
    adv_z    = cursor_z;
    adv_grp  = cursor_group;
    adv_last = 1'b0;
    if (x1 >= ex) begin
      adv_x = '0;
      adv_y = y1[AB-1:0];
      if (y1 >= ey) begin
        adv_y = '0;
        adv_z = z1[AB-1:0];
        if (z1 >= ez) begin
          adv_z = '0;
          if (adv_nxt[2]) begin
            adv_grp = adv_nxt[1:0];
          end else begin
            adv_grp  = adv_wrap[1:0];
            adv_last = 1'b1;
          end
        end
      end
    end
  end

  // shared multiply-add operand selection
  logic [2:0]       mac_k;
  logic [2:0]       mac_c;
  logic [NW-1:0]    mac_a;
  logic [VTX_W-1:0] mac_b, mac_cin_v, mac_r;
  logic             mac_cin;

  always_comb begin
    mac_k     = 3'(step - 4'd3);
    mac_c     = corner(wkind, wgrp, mac_k);
    mac_a     = n0;
    mac_b     = '0;
    mac_cin_v = '0;
    mac_cin   = 1'b0;
    case (step)
      4'd0: begin
        mac_a     = n1;
        mac_b     = VTX_W'(wz);
        mac_cin_v = VTX_W'(wy);
      end
      4'd1: begin
        mac_b     = t_acc;
        mac_cin_v = VTX_W'(wx);
      end
      4'd2: begin
        mac_b     = VTX_W'(n1);
        mac_cin_v = base;
      end
      default: begin
        mac_b     = VTX_W'(mac_c[1]);
        mac_cin_v = mac_c[2] ? base_z : base;
        mac_cin   = mac_c[0];
      end
    endcase
  end

  gev_mac #(.AW(NW)) u_mac (
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_cin_v),
    .cin (mac_cin),
    .r   (mac_r)
  );

  // divider: number / (nx-1), then quotient / (ny-1)
  logic             div_start, div_done;
  logic [VTX_W-1:0] div_dividend, div_quo;
  logic [AB-1:0]    div_divisor, div_rem;

  assign div_start    = (accept && in_func == F_LOOKUP && grid_ok) ||
                        (state == S_DIV1 && div_done);
  assign div_dividend = (state == S_IDLE) ? in_num : div_quo;
  assign div_divisor  = (state == S_IDLE) ? nm0[AB-1:0] : nm1[AB-1:0];

  gev_div #(.DW(AB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  logic [OUT_TDATA_W-1:0] out_word;

  always_comb begin
    out_word = '0;
    for (int k = 0; k < 8; k++) out_word[k*VTX_W +: VTX_W] = vtx[k];
    out_word[8*VTX_W +: VCNT_W] = res_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      cursor_kind  <= K_EDGE;
      cursor_group <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      cursor_z     <= '0;
      is_list      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            step <= '0;
            if (in_func == F_LOOKUP) begin
              is_list <= 1'b0;
              state   <= grid_ok ? S_DIV1 : S_DONE;
            end else begin
              cursor_kind  <= in_func;
              cursor_group <= dec_grp;
              cursor_x     <= dec_x;
              cursor_y     <= dec_y;
              cursor_z     <= dec_z;
              is_list      <= !dec_empty;
              state        <= dec_empty ? S_DONE : S_MAC;
            end
          end
        end
        S_DIV1: begin
          if (div_done) state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) state <= (div_quo >= VTX_W'(nm2)) ? S_DONE : S_MAC;
        end
        S_MAC: begin
          if (step == 4'd2 + res_count) state <= S_DONE;
          else step <= step + 4'd1;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
            if (is_list) begin
              cursor_group <= adv_grp;
              cursor_x     <= adv_x;
              cursor_y     <= adv_y;
              cursor_z     <= adv_z;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          for (int k = 0; k < 8; k++) vtx[k] <= '0;
          res_last <= 1'b0;
          if (in_func == F_LOOKUP) begin
            res_status <= grid_ok ? ST_OK : ST_EMPTY;
            res_count  <= '0;
          end else begin
            res_status <= dec_empty ? ST_EMPTY : ST_OK;
            res_count  <= dec_empty ? '0 : vcount(in_func);
            wkind      <= in_func;
            wgrp       <= dec_grp;
            wx         <= dec_x;
            wy         <= dec_y;
            wz         <= dec_z;
          end
        end
      end
      S_DIV1: begin
        if (div_done) wx <= div_rem;
      end
      S_DIV2: begin
        if (div_done) begin
          if (div_quo >= VTX_W'(nm2)) begin
            res_status <= ST_RANGE;
            res_count  <= '0;
          end else begin
            res_status <= ST_OK;
            res_count  <= vcount(K_CUBE);
            wkind      <= K_CUBE;
            wgrp       <= 2'd0;
            wy         <= div_rem;
            wz         <= div_quo[AB-1:0];
            // final cube sits one below the cube count on every axis
            res_last   <= ({1'b0, wx} == nm0 - NW'(1)) &&
                          ({1'b0, div_rem} == nm1 - NW'(1)) &&
                          (div_quo == VTX_W'(nm2 - NW'(1)));
          end
        end
      end
      S_MAC: begin
        case (step)
          4'd0:    t_acc  <= mac_r;
          4'd1:    base   <= mac_r;
          4'd2:    base_z <= mac_r;
          default: vtx[mac_k] <= mac_r;
        endcase
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= out_word;
          m_tuser <= res_status;
          m_tlast <= is_list ? adv_last : res_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
